[hdl/sclp_pkg.sv]
// Package for the serial command line parser: byte codes, field and
// number phase enums, result word layout. No dependencies.
package sclp_pkg;

  localparam int MAX_ARG_CHARS = 15;
  localparam int CNT_W = $clog2(MAX_ARG_CHARS + 1);

  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_FF    = 8'd12;
  localparam logic [7:0] BYTE_PLUS  = 8'h2B;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    FLD_CMD  = 2'd0,
    FLD_ARG1 = 2'd1,
    FLD_ARG2 = 2'd2
  } field_t;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_ACTIVE = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  typedef struct packed {
    logic [7:0]         command;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic [1:0]         fields_seen;
  } result_t;

endpackage

[hdl/serial_command_line_parser_unit.sv]
// Serial command line parser top level: line state, decimal conversion,
// result register with skid slot. Depends on sclp_pkg.
//
// Takes one received byte per cycle while in_stall is low. A carriage return
// emits one result word (command letter, two saturated atoi-style values,
// number of argument fields opened) into the output register, or into the skid
// slot while the output register holds a word not taken, and clears the line
// state; other bytes emit nothing. Each digit is a multiply-by-ten accumulate on
// the magnitude register. The result channel has an output register and one skid
// slot; in_stall rises only while the skid slot holds a word, i.e. after two results are pending downstream.
module serial_command_line_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_command,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_second_value,
  output logic [1:0]         out_fields_seen
);
  import sclp_pkg::*;

  field_t                 field_r, field_nxt;
  num_phase_t             phase_r, phase_nxt;
  logic [7:0]             cmd_r, cmd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic [31:0]            mag_r, mag_nxt;
  logic [31:0]            held_r, held_nxt;

  result_t                out_r, out_nxt;
  result_t                skid_r, skid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;

  logic                   in_acc;
  logic                   out_take;
  logic                   is_digit;
  logic                   is_ws;
  logic [35:0]            mag_x10;
  logic [31:0]            mag_acc;
  logic [31:0]            num_value;
  result_t                res;
  logic                   res_new;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  assign is_digit = (in_rx_byte >= BYTE_ZERO) && (in_rx_byte <= BYTE_NINE);
  assign is_ws    = (in_rx_byte >= BYTE_TAB) && (in_rx_byte <= BYTE_FF);

  // mag * 10 + digit, capped at 2^31
  assign mag_x10 = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0}
                 + {32'd0, in_rx_byte[3:0]};
  assign mag_acc = (mag_x10 > {4'd0, MAG_CAP}) ? MAG_CAP : mag_x10[31:0];

  assign num_value = neg_r ? (32'd0 - mag_r) : ((mag_r > POS_MAX) ? POS_MAX : mag_r);

  always_comb begin
    res.command      = cmd_r;
    res.first_value  = '0;
    res.second_value = '0;
    res.fields_seen  = field_r;
    unique case (field_r)
      FLD_ARG1: res.first_value = num_value;
      FLD_ARG2: begin
        res.first_value  = held_r;
        res.second_value = num_value;
      end
      default: ;
    endcase
  end

  always_comb begin
    field_nxt = field_r;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    held_nxt  = held_r;
    res_new   = 1'b0;
    if (in_acc) begin
      if (in_rx_byte == BYTE_CR) begin
        res_new   = 1'b1;
        field_nxt = FLD_CMD;
        cmd_nxt   = '0;
        held_nxt  = '0;
        cnt_nxt   = '0;
        phase_nxt = NUM_SKIP;
        neg_nxt   = 1'b0;
        mag_nxt   = '0;
      end else if (in_rx_byte == BYTE_SPACE) begin
        unique case (field_r)
          FLD_CMD: begin
            field_nxt = FLD_ARG1;
            cnt_nxt   = '0;
            phase_nxt = NUM_SKIP;
            neg_nxt   = 1'b0;
            mag_nxt   = '0;
          end
          FLD_ARG1: begin
            held_nxt  = num_value;
            field_nxt = FLD_ARG2;
            cnt_nxt   = '0;
            phase_nxt = NUM_SKIP;
            neg_nxt   = 1'b0;
            mag_nxt   = '0;
          end
          default: ;
        endcase
      end else if (field_r == FLD_CMD) begin
        cmd_nxt = in_rx_byte;
      end else if (cnt_r < CNT_W'(MAX_ARG_CHARS)) begin
        cnt_nxt = cnt_r + 1'b1;
        unique case (phase_r)
          NUM_SKIP: begin
            if (in_rx_byte == BYTE_MINUS || in_rx_byte == BYTE_PLUS) begin
              neg_nxt   = (in_rx_byte == BYTE_MINUS);
              phase_nxt = NUM_ACTIVE;
            end else if (!is_ws) begin
              // first byte of the number itself
              if (is_digit) begin
                mag_nxt   = mag_acc;
                phase_nxt = NUM_ACTIVE;
              end else begin
                phase_nxt = NUM_DONE;
              end
            end
          end
          NUM_ACTIVE: begin
            if (is_digit) begin
              mag_nxt = mag_acc;
            end else begin
              phase_nxt = NUM_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // output register plus skid slot
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_new) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r      <= FLD_CMD;
      phase_r      <= NUM_SKIP;
      cmd_r        <= '0;
      cnt_r        <= '0;
      neg_r        <= 1'b0;
      mag_r        <= '0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      field_r      <= field_nxt;
      phase_r      <= phase_nxt;
      cmd_r        <= cmd_nxt;
      cnt_r        <= cnt_nxt;
      neg_r        <= neg_nxt;
      mag_r        <= mag_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_command      = out_r.command;
  assign out_first_value  = out_r.first_value;
  assign out_second_value = out_r.second_value;
  assign out_fields_seen  = out_r.fields_seen;

endmodule

[tb/sv/serial_command_line_parser_unit_test.sv]
// Self-checking testbench for serial_command_line_parser_unit: directed and random
// byte streams, a local line parser that predicts each result word, varying idle/stall.
// Depends on sclp_pkg and the RTL top level only.
module serial_command_line_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sclp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 280;
  localparam int TAIL_CYCLES  = 20;
  localparam int PRINT_LIMIT  = 100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_command;
  logic signed [31:0] out_first_value;
  logic signed [31:0] out_second_value;
  logic [1:0]         out_fields_seen;

  serial_command_line_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command     (out_command),
    .out_first_value (out_first_value),
    .out_second_value(out_second_value),
    .out_fields_seen (out_fields_seen)
  );

  // Stimulus and scoreboard storage
  logic [7:0] rx_q[$];
  result_t    pending_results[$];
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_req = 0;
  int         hold_ack = 0;
  int         hold_left = 0;
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         lines_checked = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  // Line state of the predictor
  field_t               ln_field = FLD_CMD;
  logic [7:0]           ln_cmd = 8'h00;
  logic [CNT_W-1:0]     ln_count = '0;
  num_phase_t           ln_phase = NUM_SKIP;
  logic                 ln_neg = 1'b0;
  logic [31:0]          ln_mag = '0;
  logic [31:0]          ln_held = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic void clear_arg();
    ln_count = '0;
    ln_phase = NUM_SKIP;
    ln_neg   = 1'b0;
    ln_mag   = '0;
  endfunction

  function automatic logic [31:0] arg_value();
    if (ln_neg) begin
      return 32'd0 - ln_mag;
    end
    return (ln_mag > POS_MAX) ? POS_MAX : ln_mag;
  endfunction

  // atoi-style accumulation of one kept argument byte
  function automatic void feed_arg(input logic [7:0] b);
    logic [63:0] acc;
    if (ln_phase == NUM_SKIP) begin
      if (b >= BYTE_TAB && b <= BYTE_FF) begin
        return;
      end
      if (b == BYTE_MINUS || b == BYTE_PLUS) begin
        ln_neg   = (b == BYTE_MINUS);
        ln_phase = NUM_ACTIVE;
        return;
      end
      ln_phase = NUM_ACTIVE;
    end
    if (ln_phase == NUM_ACTIVE) begin
      if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
        acc = 64'(ln_mag) * 64'd10 + 64'(b - BYTE_ZERO);
        ln_mag = (acc > 64'(MAG_CAP)) ? MAG_CAP : acc[31:0];
      end else begin
        ln_phase = NUM_DONE;
      end
    end
  endfunction

  // Advance the predicted line state by one accepted byte
  function automatic void parse_byte(input logic [7:0] b);
    result_t r;
    if (b == BYTE_CR) begin
      r.command      = ln_cmd;
      r.first_value  = (ln_field == FLD_ARG1) ? arg_value() :
                       (ln_field == FLD_ARG2) ? ln_held : 32'd0;
      r.second_value = (ln_field == FLD_ARG2) ? arg_value() : 32'd0;
      r.fields_seen  = ln_field;
      pending_results.push_back(r);
      ln_field = FLD_CMD;
      ln_cmd   = 8'h00;
      ln_held  = '0;
      clear_arg();
    end else if (b == BYTE_SPACE) begin
      if (ln_field == FLD_CMD) begin
        ln_field = FLD_ARG1;
        clear_arg();
      end else if (ln_field == FLD_ARG1) begin
        ln_held  = arg_value();
        ln_field = FLD_ARG2;
        clear_arg();
      end
    end else if (ln_field == FLD_CMD) begin
      ln_cmd = b;
    end else if (ln_count < MAX_ARG_CHARS) begin
      ln_count++;
      feed_arg(b);
    end
  endfunction

  task automatic push_byte(input logic [7:0] b);
    rx_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255, 0));
    end while (b == BYTE_CR || b == BYTE_SPACE);
    return b;
  endfunction

  function automatic string sign_text();
    case ($urandom_range(3, 0))
      0:       return "-";
      1:       return "+";
      default: return "";
    endcase
  endfunction

  task automatic queue_random_arg();
    int         n;
    int signed  v;
    string      s;
    repeat (($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0) begin
      push_byte(8'($urandom_range(BYTE_FF, BYTE_TAB)));
    end
    case ($urandom_range(9, 0))
      0, 1, 2, 3: push_text({sign_text(), $sformatf("%0d", $urandom_range(999, 0))});
      4, 5: begin
        v = int'($urandom());
        push_text($sformatf("%0d", v));
      end
      6: begin
        case ($urandom_range(5, 0))
          0:       push_text("2147483647");
          1:       push_text("-2147483648");
          2:       push_text("2147483648");
          3:       push_text("-2147483649");
          4:       push_text("-0");
          default: push_text("+2147483646");
        endcase
      end
      7: begin
        // long digit run: overflow and the kept-byte limit
        s = sign_text();
        n = $urandom_range(20, 11);
        repeat (n) s = {s, $sformatf("%0d", $urandom_range(9, 0))};
        push_text(s);
      end
      8: push_text(sign_text());
      default: begin
        repeat ($urandom_range(4, 1)) push_byte(plain_byte());
      end
    endcase
    if ($urandom_range(3, 0) == 0) begin
      push_byte(plain_byte());
    end
  endtask

  task automatic queue_random_line();
    int nf;
    if ($urandom_range(9, 0) == 0) begin
      // noise: raw bytes, spaces and returns included
      repeat ($urandom_range(20, 1)) push_byte(8'($urandom_range(255, 0)));
      push_byte(BYTE_CR);
      return;
    end
    repeat (($urandom_range(4, 0) == 0) ? $urandom_range(3, 0) : 1) begin
      if ($urandom_range(3, 0) == 0) begin
        push_byte(plain_byte());
      end else begin
        push_byte(8'($urandom_range(8'h5A, 8'h41) | ($urandom_range(1, 0) << 5)));
      end
    end
    nf = $urandom_range(5, 0);
    if (nf >= 1) begin
      push_byte(BYTE_SPACE);
      queue_random_arg();
    end
    if (nf >= 3) begin
      push_byte(BYTE_SPACE);
      queue_random_arg();
      if ($urandom_range(3, 0) == 0) begin
        push_byte(BYTE_SPACE);
        push_byte(plain_byte());
        push_byte(BYTE_SPACE);
      end
    end
    push_byte(BYTE_CR);
  endtask

  // Sender: offer queued bytes, hold the word while stalled
  always @(posedge clk) begin : drive_bytes
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        bytes_taken++;
        parse_byte(in_rx_byte);
      end
      if (!in_valid || took) begin
        if (rx_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_rx_byte <= rx_q.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold, counted down on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end
  end

  // Receiver: check each accepted word against the oldest prediction
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        lines_checked++;
        if (pending_results.size() == 0) begin
          flag_mismatch("result word with none expected");
        end else begin
          want = pending_results.pop_front();
          if (out_command !== want.command)
            flag_mismatch($sformatf("command got %0h want %0h", out_command, want.command));
          if (out_first_value !== want.first_value)
            flag_mismatch($sformatf("first_value got %0d want %0d",
                                    out_first_value, want.first_value));
          if (out_second_value !== want.second_value)
            flag_mismatch($sformatf("second_value got %0d want %0d",
                                    out_second_value, want.second_value));
          if (out_fields_seen !== want.fields_seen)
            flag_mismatch($sformatf("fields_seen got %0d want %0d",
                                    out_fields_seen, want.fields_seen));
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99, 0) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_sent();
    @(posedge clk);
    while (rx_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin : run_stimulus
    int send_tab[5]  = '{0, 64, 0, 12, 0};
    int stall_tab[5] = '{0, 0, 64, 12, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty line
    push_byte(BYTE_CR);
    // Zero command byte, skipped tab, sign, zero byte ending a number,
    // later spaces, plus sign before a non-digit
    push_byte(8'h00);
    push_byte(BYTE_SPACE);
    push_byte(BYTE_TAB);
    push_byte(BYTE_MINUS);
    push_text("5");
    push_byte(8'h00);
    push_text("7");
    push_byte(BYTE_SPACE);
    push_byte(BYTE_SPACE);
    push_byte(BYTE_PLUS);
    push_byte(8'hFF);
    push_byte(BYTE_CR);
    // Positive overflow saturates
    push_byte(8'hFF);
    push_text(" 2147483648");
    push_byte(BYTE_CR);
    wait_sent();

    for (int p = 0; p < 5; p++) begin
      @(negedge clk);
      send_idle_pct = send_tab[p];
      stall_pct     = stall_tab[p];
      // last pattern: hold the output while bytes keep coming
      if (p == 4) hold_req++;
      while (rx_q.size() < PHASE_BYTES) queue_random_line();
      wait_sent();
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Sent %0d of %0d queued bytes, checked %0d result words over five idle/stall patterns",
             bytes_taken, bytes_queued, lines_checked);
    $display("including a %0d-cycle output hold; %0d mismatches", HOLD_CYCLES,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sclp_pkg.sv
hdl/serial_command_line_parser_unit.sv
tb/sv/serial_command_line_parser_unit_test.sv
